// ===== hw/rtl/cpio_newc_stream_parser_macros.svh =====
// assertion helpers for the parser core
`ifndef CPIO_NEWC_STREAM_PARSER_MACROS_SVH
`define CPIO_NEWC_STREAM_PARSER_MACROS_SVH

// property checked on every rising edge outside reset
`define CNP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define CNP_NEVER(lbl, clk, rst, cond, msg) \
  `CNP_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

// ===== hw/rtl/cnp_pkg.sv =====
`default_nettype none
package cnp_pkg;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_HDR_CHAR   = 3'd0;
  localparam kind_t KIND_FIELD_DONE = 3'd1;
  localparam kind_t KIND_NAME       = 3'd2;
  localparam kind_t KIND_DATA       = 3'd3;
  localparam kind_t KIND_PAD        = 3'd4;
  localparam kind_t KIND_ERROR      = 3'd5;
  localparam kind_t KIND_IGNORED    = 3'd6;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  field_index;
    logic [31:0] field_value;
    logic [7:0]  byte_echo;
    logic        entry_last;
    logic        archive_end;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cnp_in_stage.sv =====
`default_nettype none
module cnp_in_stage
  import cnp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       take,
  output logic            valid,
  output logic [7:0]      in_byte
);

  logic advance;

  assign advance  = valid && take;
  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cnp_core.sv =====
`default_nettype none
`include "cpio_newc_stream_parser_macros.svh"
module cnp_core
  import cnp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic [7:0] in_byte,
  output result_t         res
);

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_NAME    = 7'b0000010,
    PH_NAMEPAD = 7'b0000100,
    PH_DATA    = 7'b0001000,
    PH_DATAPAD = 7'b0010000,
    PH_ERROR   = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  localparam logic [31:0] MAGIC_VALUE    = 32'h0000_71C2;
  localparam logic [3:0]  FIELD_FILESIZE = 4'd7;
  localparam logic [3:0]  FIELD_NAMESIZE = 4'd12;
  localparam logic [3:0]  LAST_FIELD     = 4'd13;
  localparam logic [3:0]  TRAILER_LEN    = 4'd10;
  localparam logic [2:0]  MAGIC_LAST     = 3'd5;
  localparam logic [2:0]  HEX_LAST       = 3'd7;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c inside {[8'h30:8'h39]}) d = 4'(c - 8'h30);
    else if (c inside {[8'h41:8'h46]}) d = 4'(c - 8'h37);
    else if (c inside {[8'h61:8'h66]}) d = 4'(c - 8'h57);
    return d;
  endfunction

  function automatic logic [7:0] magic_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd1, 3'd3: c = 8'h37;
      3'd5:       c = 8'h32;
      default:    c = 8'h30;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      default: c = 8'h21;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] name_pad(input logic [1:0] m);
    logic [1:0] p;
    case (m)
      2'd0:    p = 2'd2;
      2'd1:    p = 2'd1;
      2'd2:    p = 2'd0;
      default: p = 2'd3;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] file_pad(input logic [1:0] m);
    return 2'(3'd4 - {1'b0, m});
  endfunction

  phase_t      phase, phase_next;
  logic [3:0]  field_number, field_number_next;
  logic [2:0]  char_in_field, char_in_field_next;
  logic [31:0] accumulator, accumulator_next;
  logic [31:0] name_length, name_length_next;
  logic [31:0] file_length, file_length_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [3:0]  name_position, name_position_next;
  logic        trailer_match, trailer_match_next;
  logic        magic_ok, magic_ok_next;

  // segment search: name, name pad, data, data pad
  logic [31:0] seg_len [4];
  logic [2:0]  seg_first;
  logic        seg_found;
  logic [1:0]  seg_sel;
  phase_t      seg_phase;

  always_comb begin
    seg_len[0] = name_length;
    seg_len[1] = {30'd0, name_pad(name_length[1:0])};
    seg_len[2] = file_length;
    seg_len[3] = {30'd0, file_pad(file_length[1:0])};
    case (phase)
      PH_HEADER:  seg_first = 3'd0;
      PH_NAME:    seg_first = 3'd1;
      PH_NAMEPAD: seg_first = 3'd2;
      PH_DATA:    seg_first = 3'd3;
      default:    seg_first = 3'd4;
    endcase
    seg_found = 1'b0;
    seg_sel   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (!seg_found && 3'(i) >= seg_first && seg_len[i] != 32'd0) begin
        seg_found = 1'b1;
        seg_sel   = 2'(i);
      end
    end
    case (seg_sel)
      2'd0:    seg_phase = PH_NAME;
      2'd1:    seg_phase = PH_NAMEPAD;
      2'd2:    seg_phase = PH_DATA;
      default: seg_phase = PH_DATAPAD;
    endcase
  end

  logic [31:0] acc_new;
  logic [31:0] bl_dec;
  logic        mok;
  logic        ended;
  logic        in_body;

  assign acc_new = {accumulator[27:0], hex_digit(in_byte)};
  assign bl_dec  = bytes_left - {31'd0, (bytes_left != 32'd0)};
  assign in_body = phase inside {PH_NAME, PH_NAMEPAD, PH_DATA, PH_DATAPAD};

  always_comb begin
    phase_next         = phase;
    field_number_next  = field_number;
    char_in_field_next = char_in_field;
    accumulator_next   = accumulator;
    name_length_next   = name_length;
    file_length_next   = file_length;
    bytes_left_next    = bytes_left;
    name_position_next = name_position;
    trailer_match_next = trailer_match;
    magic_ok_next      = magic_ok;
    res                = '0;
    res.kind           = KIND_IGNORED;
    ended              = 1'b0;
    mok                = magic_ok && (char_in_field <= MAGIC_LAST)
                         && (in_byte == magic_char(char_in_field));

    case (phase)
      PH_HEADER: begin
        if (field_number == 4'd0) begin
          magic_ok_next = mok;
          if (char_in_field >= MAGIC_LAST) begin
            if (!mok) begin
              phase_next = PH_ERROR;
              res.kind   = KIND_ERROR;
            end else begin
              res.kind           = KIND_FIELD_DONE;
              res.field_value    = MAGIC_VALUE;
              field_number_next  = 4'd1;
              char_in_field_next = 3'd0;
              accumulator_next   = 32'd0;
            end
          end else begin
            res.kind           = KIND_HDR_CHAR;
            char_in_field_next = char_in_field + 3'd1;
          end
        end else begin
          res.field_index  = field_number;
          accumulator_next = acc_new;
          if (char_in_field >= HEX_LAST) begin
            res.kind        = KIND_FIELD_DONE;
            res.field_value = acc_new;
            if (field_number == FIELD_FILESIZE) file_length_next = acc_new;
            if (field_number == FIELD_NAMESIZE) name_length_next = acc_new;
            accumulator_next   = 32'd0;
            char_in_field_next = 3'd0;
            if (field_number >= LAST_FIELD) begin
              ended = !seg_found;
              if (seg_found) begin
                phase_next      = seg_phase;
                bytes_left_next = seg_len[seg_sel];
              end
            end else begin
              field_number_next = field_number + 4'd1;
            end
          end else begin
            res.kind           = KIND_HDR_CHAR;
            char_in_field_next = char_in_field + 3'd1;
          end
        end
      end
      PH_NAME, PH_NAMEPAD, PH_DATA, PH_DATAPAD: begin
        if (phase == PH_NAME) begin
          res.kind      = KIND_NAME;
          res.byte_echo = in_byte;
          if (name_position < TRAILER_LEN) begin
            if (in_byte != trailer_char(name_position)) trailer_match_next = 1'b0;
          end else if (name_position == TRAILER_LEN) begin
            if (in_byte != 8'd0) trailer_match_next = 1'b0;
          end
          if (name_position <= TRAILER_LEN) name_position_next = name_position + 4'd1;
        end else if (phase == PH_DATA) begin
          res.kind      = KIND_DATA;
          res.byte_echo = in_byte;
        end else begin
          res.kind = KIND_PAD;
        end
        bytes_left_next = bl_dec;
        if (bl_dec == 32'd0) begin
          ended = !seg_found;
          if (seg_found) begin
            phase_next      = seg_phase;
            bytes_left_next = seg_len[seg_sel];
          end
        end
      end
      PH_ERROR: begin
        res.kind = KIND_ERROR;
      end
      default: begin
        res.kind = KIND_IGNORED;
      end
    endcase

    if (ended) begin
      res.entry_last  = 1'b1;
      res.archive_end = trailer_match_next && (name_position_next > TRAILER_LEN);
      phase_next         = res.archive_end ? PH_DONE : PH_HEADER;
      field_number_next  = 4'd0;
      char_in_field_next = 3'd0;
      accumulator_next   = 32'd0;
      name_length_next   = 32'd0;
      file_length_next   = 32'd0;
      bytes_left_next    = 32'd0;
      name_position_next = 4'd0;
      trailer_match_next = 1'b1;
      magic_ok_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      field_number  <= 4'd0;
      char_in_field <= 3'd0;
      accumulator   <= 32'd0;
      name_length   <= 32'd0;
      file_length   <= 32'd0;
      bytes_left    <= 32'd0;
      name_position <= 4'd0;
      trailer_match <= 1'b1;
      magic_ok      <= 1'b1;
    end else if (adv) begin
      phase         <= phase_next;
      field_number  <= field_number_next;
      char_in_field <= char_in_field_next;
      accumulator   <= accumulator_next;
      name_length   <= name_length_next;
      file_length   <= file_length_next;
      bytes_left    <= bytes_left_next;
      name_position <= name_position_next;
      trailer_match <= trailer_match_next;
      magic_ok      <= magic_ok_next;
    end
  end

  `CNP_ASSERT(a_end_goes_done, clk, rst, (adv && res.archive_end) |=> (phase == PH_DONE),
              "archive end did not stop parsing")
  `CNP_ASSERT(a_error_sticky, clk, rst, (phase == PH_ERROR) |=> (phase == PH_ERROR),
              "error state left before reset")
  `CNP_NEVER(a_empty_segment, clk, rst, in_body && (bytes_left == 32'd0),
             "body segment with no bytes left")
  `CNP_NEVER(a_fields_need_magic, clk, rst, (field_number != 4'd0) && !magic_ok,
             "hex fields parsed after bad magic")

endmodule
`default_nettype wire

// ===== hw/rtl/cnp_out_stage.sv =====
`default_nettype none
module cnp_out_stage
  import cnp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         take,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output result_t      res_out
);

  assign take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cpio_newc_stream_parser.sv =====
// channel   dir  tdata                         tuser                  tlast
// s_axis    in   [7:0] in_byte                 -                      -
// m_axis    out  [3:0] field_index,            [2:0] kind,            entry_last
//                [35:4] field_value,           [3] archive_end
//                [43:36] byte_echo, rest zero
//
// one request in, one request out, one byte per cycle sustained while m_tready stays high
// path: input register, then parse logic into the result register
// the parse state updates only when a byte moves from the input register to the result register
// a stalled master side holds the result; the input register still takes one more byte
// rst is synchronous and active high, clears the valid flags of both stages and all parse state
`default_nettype none
module cpio_newc_stream_parser
  import cnp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [3:0] field_index, [35:4] field_value, [43:36] byte_echo
  output logic [3:0]       m_tuser,   // [2:0] kind, [3] archive_end
  output logic             m_tlast    // entry_last
);

  logic       take;      // result register can accept a new request
  logic       in_valid;
  logic [7:0] in_byte;
  logic       adv;       // byte moves into the parser this cycle
  result_t    res_comb;
  result_t    res_q;

  assign adv = in_valid && take;

  cnp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .valid    (in_valid),
    .in_byte  (in_byte)
  );

  // header fields, name/data segments and trailer detection
  cnp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_byte (in_byte),
    .res     (res_comb)
  );

  cnp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (adv),
    .res_in   (res_comb),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res_out  (res_q)
  );

  // pack the result request onto the master side
  assign m_tdata = {4'd0, res_q.byte_echo, res_q.field_value, res_q.field_index};
  assign m_tuser = {res_q.archive_end, res_q.kind};
  assign m_tlast = res_q.entry_last;

endmodule
`default_nettype wire
